// ----- src/lcp_pkg.sv -----
// shared types and constants for the lfu cache policy block
package lcp_pkg;

  // request sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DECIDE,
    ST_UNLINK,
    ST_UPDATE,
    ST_INSERT,
    ST_RESP
  } state_t;

  // operation codes carried on the mode field
  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  // read value returned by a get that misses
  localparam logic [31:0] MISS_VALUE = 32'hFFFF_FFFF;

  // capacity register
  localparam int          CAP_W     = 5;
  localparam logic [4:0]  CAP_RESET = 5'd16;

endpackage

// ----- src/lcp_ram.sv -----
// generic single-write, single-read ram with registered read data
module lcp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/lfu_cache_policy_top.sv -----
// Fully associative key/value cache with least-frequently-used replacement and a
// least-recently-used tie break. Keys, values, use counts and recency ranks live in
// four small rams that one scan counter walks with a single read address, so each
// request is served one entry per cycle. Every request runs a search scan and a decide
// state. When nothing is stored and no rank changes (get miss, put with zero capacity)
// the result follows; a put that fills a free entry of a cache that is not full first
// passes the insert state; when an entry is touched or evicted, the ranks above the
// removed position are renumbered in a second scan of the rank ram before the update
// or insert state. The input side stalls while a request is in flight and takes the
// next word in the cycle after the result is loaded; the finished word sits in an
// output register, so the next word is taken while the result waits.
module lfu_cache_policy_top #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration: capacity_in_use
  input  logic               cfg_write_en,
  input  logic [4:0]         cfg_write_data,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic signed [31:0] key,
  input  logic signed [31:0] value,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               hit,
  output logic signed [31:0] read_value,
  output logic               evicted,
  output logic signed [31:0] evicted_key
);

  import lcp_pkg::*;

  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W = IDX_W;
  localparam int OCC_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam logic [IDX_W:0]      SCAN_END  = (IDX_W + 1)'(ENTRIES);
  localparam logic [CMP_W-1:0]    ENT_CMP   = CMP_W'(ENTRIES);
  localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  state_t state, state_next;

  // configuration and occupancy
  logic [CAP_W-1:0]   cap;
  logic [ENTRIES-1:0] valid_q;
  logic [OCC_W-1:0]   occ;
  logic [OCC_W-1:0]   occ_dec;

  // captured request
  logic        req_mode;
  logic [31:0] req_key;
  logic [31:0] req_value;

  // scan control
  logic [IDX_W:0]   scan;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;

  // search results
  logic                  hit_f;
  logic [IDX_W-1:0]      slot;
  logic [31:0]           slot_data;
  logic [COUNT_BITS-1:0] slot_count;
  logic [RANK_W-1:0]     slot_rank;
  logic                  vic_f;
  logic [IDX_W-1:0]      vic_slot;
  logic [COUNT_BITS-1:0] vic_count;
  logic [RANK_W-1:0]     vic_rank;
  logic [31:0]           vic_key;
  logic                  free_f;
  logic [IDX_W-1:0]      free_slot;

  // action for the rest of the request
  logic [IDX_W-1:0]  tgt_slot;
  logic [RANK_W-1:0] tgt_rank;
  logic              do_ins;
  logic [IDX_W-1:0]  ins_slot;
  logic [RANK_W-1:0] ins_rank;

  // pending result
  logic        res_hit;
  logic [31:0] res_rd;
  logic        res_ev;
  logic [31:0] res_evkey;

  // ram ports
  logic [IDX_W-1:0]      raddr;
  logic [IDX_W-1:0]      waddr;
  logic                  key_we, data_we, count_we, rank_we;
  logic [31:0]           key_wdata, data_wdata;
  logic [COUNT_BITS-1:0] count_wdata;
  logic [RANK_W-1:0]     rank_wdata;
  logic [31:0]           key_rd, data_rd;
  logic [COUNT_BITS-1:0] count_rd;
  logic [RANK_W-1:0]     rank_rd;

  // decision terms
  logic [CMP_W-1:0] cap_ext, cap_eff;
  logic             cap_zero, is_full;
  logic             act_touch, act_evict, act_insert;
  logic             in_accept, out_load, rd_live;
  logic [COUNT_BITS-1:0] count_inc;

  // entry stores
  lcp_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key_ram (
    .clk(clk), .we(key_we), .waddr(waddr), .wdata(key_wdata),
    .raddr(raddr), .rdata(key_rd)
  );

  lcp_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_data_ram (
    .clk(clk), .we(data_we), .waddr(waddr), .wdata(data_wdata),
    .raddr(raddr), .rdata(data_rd)
  );

  lcp_ram #(.WIDTH(COUNT_BITS), .DEPTH(ENTRIES)) u_count_ram (
    .clk(clk), .we(count_we), .waddr(waddr), .wdata(count_wdata),
    .raddr(raddr), .rdata(count_rd)
  );

  lcp_ram #(.WIDTH(RANK_W), .DEPTH(ENTRIES)) u_rank_ram (
    .clk(clk), .we(rank_we), .waddr(waddr), .wdata(rank_wdata),
    .raddr(raddr), .rdata(rank_rd)
  );

  // handshake terms
  assign in_accept = in_valid && (state == ST_IDLE);
  assign out_load  = (state == ST_RESP) && (!out_valid || !out_stall);
  assign rd_live   = rd_vld && valid_q[rd_idx];

  // capacity limits and occupancy compare
  assign cap_ext  = CMP_W'(cap);
  assign cap_eff  = (cap_ext > ENT_CMP) ? ENT_CMP : cap_ext;
  assign cap_zero = (cap == '0);
  assign is_full  = (CMP_W'(occ) >= cap_eff);
  assign occ_dec  = occ - 1'b1;

  // what the request does once the scan is over
  assign act_touch  = hit_f && ((req_mode == MODE_GET) || !cap_zero);
  assign act_insert = !hit_f && (req_mode == MODE_PUT) && !cap_zero;
  assign act_evict  = act_insert && is_full;

  assign count_inc = (slot_count == COUNT_MAX) ? slot_count : slot_count + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (scan == SCAN_END) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (act_touch || act_evict) begin
          state_next = ST_UNLINK;
        end else if (act_insert) begin
          state_next = ST_INSERT;
        end else begin
          state_next = ST_RESP;
        end
      end
      ST_UNLINK: begin
        if (scan == SCAN_END) state_next = do_ins ? ST_INSERT : ST_UPDATE;
      end
      ST_UPDATE: state_next = ST_RESP;
      ST_INSERT: state_next = ST_RESP;
      ST_RESP: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ram controls and stall
  always_comb begin
    in_stall    = (state != ST_IDLE);
    raddr       = scan[IDX_W-1:0];
    waddr       = rd_idx;
    key_we      = 1'b0;
    data_we     = 1'b0;
    count_we    = 1'b0;
    rank_we     = 1'b0;
    key_wdata   = req_key;
    data_wdata  = req_value;
    count_wdata = count_inc;
    rank_wdata  = rank_rd - 1'b1;
    case (state)
      ST_UNLINK: begin
        // close the gap left by the touched or evicted entry
        rank_we = rd_live && (rd_idx != tgt_slot) && (rank_rd > tgt_rank);
      end
      ST_UPDATE: begin
        waddr      = tgt_slot;
        count_we   = 1'b1;
        rank_we    = 1'b1;
        rank_wdata = occ_dec[RANK_W-1:0];
        data_we    = (req_mode == MODE_PUT);
      end
      ST_INSERT: begin
        waddr       = ins_slot;
        key_we      = 1'b1;
        data_we     = 1'b1;
        count_we    = 1'b1;
        rank_we     = 1'b1;
        count_wdata = COUNT_ONE;
        rank_wdata  = ins_rank;
      end
      default: begin
        rank_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cap       <= CAP_RESET;
      valid_q   <= '0;
      occ       <= '0;
      scan      <= '0;
      rd_vld    <= 1'b0;
      hit_f     <= 1'b0;
      vic_f     <= 1'b0;
      free_f    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) cap <= cfg_write_data;

      // scan counter shared by the search and renumbering passes
      if ((state == ST_SEARCH) || (state == ST_UNLINK)) begin
        if (scan != SCAN_END) scan <= scan + 1'b1;
        rd_vld <= (scan != SCAN_END);
      end else begin
        scan   <= '0;
        rd_vld <= 1'b0;
      end

      // search flags
      if (in_accept) begin
        hit_f  <= 1'b0;
        vic_f  <= 1'b0;
        free_f <= 1'b0;
      end else if ((state == ST_SEARCH) && rd_vld) begin
        if (rd_live && (key_rd == req_key)) hit_f <= 1'b1;
        if (rd_live) vic_f <= 1'b1;
        if (!valid_q[rd_idx]) free_f <= 1'b1;
      end

      // occupancy changes
      if (state == ST_DECIDE) begin
        if (act_evict) begin
          valid_q[vic_slot] <= 1'b0;
        end else if (act_insert) begin
          occ <= occ + 1'b1;
        end
      end
      if (state == ST_INSERT) valid_q[ins_slot] <= 1'b1;

      // output register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst) begin
      rd_idx <= scan[IDX_W-1:0];

      if (in_accept) begin
        req_mode  <= mode;
        req_key   <= key;
        req_value <= value;
      end

      // key match, victim and first free slot in one pass
      if ((state == ST_SEARCH) && rd_vld) begin
        if (rd_live && (key_rd == req_key) && !hit_f) begin
          slot       <= rd_idx;
          slot_data  <= data_rd;
          slot_count <= count_rd;
          slot_rank  <= rank_rd;
        end
        if (rd_live && (!vic_f || (count_rd < vic_count) ||
                        ((count_rd == vic_count) && (rank_rd < vic_rank)))) begin
          vic_slot  <= rd_idx;
          vic_count <= count_rd;
          vic_rank  <= rank_rd;
          vic_key   <= key_rd;
        end
        if (!valid_q[rd_idx] && !free_f) free_slot <= rd_idx;
      end

      // settle the action and the result
      if (state == ST_DECIDE) begin
        tgt_slot <= act_touch ? slot : vic_slot;
        tgt_rank <= act_touch ? slot_rank : vic_rank;
        do_ins   <= act_insert;
        if (act_evict) begin
          ins_slot <= (free_f && (free_slot < vic_slot)) ? free_slot : vic_slot;
          ins_rank <= occ_dec[RANK_W-1:0];
        end else begin
          ins_slot <= free_slot;
          ins_rank <= occ[RANK_W-1:0];
        end
        res_hit   <= hit_f;
        res_rd    <= (req_mode == MODE_GET) ? (hit_f ? slot_data : MISS_VALUE) : '0;
        res_ev    <= act_evict;
        res_evkey <= act_evict ? vic_key : '0;
      end

      if (out_load) begin
        hit         <= res_hit;
        read_value  <= res_rd;
        evicted     <= res_ev;
        evicted_key <= res_evkey;
      end
    end
  end

endmodule

// ----- bench/lfu_cache_checker.sv -----
// result checker for the lfu cache: predicts each response and compares it on the output channel
`timescale 1ns / 1ps

module lfu_cache_checker #(
  parameter int ENTRIES    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  logic [lcp_pkg::CAP_W-1:0] cfg_write_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     mode,
  input  logic [31:0]              key,
  input  logic [31:0]              value,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic                     hit,
  input  logic [31:0]              read_value,
  input  logic                     evicted,
  input  logic [31:0]              evicted_key,
  output int                       mismatch_count,
  output int                       pending_results
);

  import lcp_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic        evicted;
    logic [31:0] evicted_key;
  } lookup_result_t;

  // shadow copy of the cache contents
  logic                  slot_valid [ENTRIES];
  logic [31:0]           slot_key   [ENTRIES];
  logic [31:0]           slot_data  [ENTRIES];
  logic [COUNT_BITS-1:0] slot_count [ENTRIES];
  int unsigned           slot_rank  [ENTRIES];
  logic [CAP_W-1:0]      capacity;

  lookup_result_t expected_q [$];
  lookup_result_t want;

  function automatic int unsigned occupied();
    int unsigned n;
    n = 0;
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i]) n++;
    return n;
  endfunction

  // close the gap in the recency order left by slot s
  function automatic void drop_rank(int s);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_valid[i] && i != s && slot_rank[i] > slot_rank[s])
        slot_rank[i]--;
  endfunction

  // a hit: most recent, count up to saturation
  function automatic void promote(int s);
    drop_rank(s);
    slot_rank[s] = occupied() - 1;
    if (slot_count[s] != '1)
      slot_count[s]++;
  endfunction

  function automatic lookup_result_t serve(logic m, logic [31:0] k, logic [31:0] v);
    lookup_result_t r;
    int slot;
    int victim;
    int unsigned eff_cap;
    int unsigned n;
    logic placed;
    r = '0;
    slot = -1;
    eff_cap = (capacity > ENTRIES) ? ENTRIES : capacity;
    for (int i = 0; i < ENTRIES; i++)
      if (slot < 0 && slot_valid[i] && slot_key[i] == k)
        slot = i;
    r.hit = (slot >= 0);
    if (m == MODE_GET) begin
      if (r.hit) begin
        r.read_value = slot_data[slot];
        promote(slot);
      end else begin
        r.read_value = MISS_VALUE;
      end
    end else if (eff_cap != 0) begin
      if (r.hit) begin
        slot_data[slot] = v;
        promote(slot);
      end else begin
        n = occupied();
        // full: lowest count goes, least recent among equal counts
        if (n >= eff_cap) begin
          victim = -1;
          for (int i = 0; i < ENTRIES; i++) begin
            if (slot_valid[i] && (victim < 0 || slot_count[i] < slot_count[victim] ||
                (slot_count[i] == slot_count[victim] && slot_rank[i] < slot_rank[victim])))
              victim = i;
          end
          if (victim >= 0) begin
            drop_rank(victim);
            slot_valid[victim] = 1'b0;
            r.evicted = 1'b1;
            r.evicted_key = slot_key[victim];
            n--;
          end
        end
        // new entry goes to the first free slot
        placed = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!placed && !slot_valid[i]) begin
            slot_valid[i] = 1'b1;
            slot_key[i]   = k;
            slot_data[i]  = v;
            slot_count[i] = COUNT_BITS'(1);
            slot_rank[i]  = n;
            placed = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  // compare outgoing words, then predict incoming ones
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) slot_valid[i] = 1'b0;
      capacity = CAP_RESET;
      expected_q.delete();
      mismatch_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("[%0t] unexpected result word: hit=%0b read=%h evicted=%0b evkey=%h",
                     $realtime, hit, read_value, evicted, evicted_key);
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          if (hit !== want.hit || read_value !== want.read_value ||
              evicted !== want.evicted || evicted_key !== want.evicted_key) begin
            if (mismatch_count < 10) begin
              $write("[%0t] result mismatch (expected/actual): hit %0b/%0b read %h/%h",
                     $realtime, want.hit, hit, want.read_value, read_value);
              $display(" evicted %0b/%0b evkey %h/%h",
                       want.evicted, evicted, want.evicted_key, evicted_key);
            end
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(serve(mode, key, value));
      if (cfg_write_en)
        capacity = cfg_write_data;
    end
    pending_results = expected_q.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// stimulus and verdict for the lfu cache block: directed requests, then random traffic phases
`timescale 1ns / 1ps

module tb_top;
  import lcp_pkg::*;

  localparam int ENTRIES        = 16;
  // narrow counters so that saturation is reachable in a short run
  localparam int COUNT_WIDTH    = 3;
  localparam int KEY_POOL       = 20;
  localparam int WATCHDOG_LIMIT = 4000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write_en = 1'b0;
  logic [CAP_W-1:0]  cfg_write_data = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              mode = MODE_GET;
  logic signed [31:0] key = '0;
  logic signed [31:0] value = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              hit;
  logic signed [31:0] read_value;
  logic              evicted;
  logic signed [31:0] evicted_key;

  int mismatch_count;
  int pending_results;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;
  logic [31:0] key_pool [KEY_POOL];

  always #5 clk = ~clk;

  lfu_cache_policy_top #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_WIDTH)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .key            (key),
    .value          (value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .hit            (hit),
    .read_value     (read_value),
    .evicted        (evicted),
    .evicted_key    (evicted_key)
  );

  lfu_cache_checker #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_WIDTH)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg_write_en    (cfg_write_en),
    .cfg_write_data  (cfg_write_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .mode            (mode),
    .key             (key),
    .value           (value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .hit             (hit),
    .read_value      (read_value),
    .evicted         (evicted),
    .evicted_key     (evicted_key),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  // result side back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles where no word moves on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // present one request word and hold it until taken
  task automatic send_request(input logic m, input logic [31:0] k, input logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (in_stall);
  endtask

  // stop sending until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_drained();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= cap;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
  endtask

  task automatic set_idling(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 77; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 77; end
      default: begin send_idle_pct = 12; stall_pct = 12; end
    endcase
  endtask

  initial begin
    logic [CAP_W-1:0] cap_plan [8];
    int n_items;
    int pick;
    logic [31:0] k;

    cap_plan = '{5'd16, 5'd3, 5'd31, 5'd1, 5'd0, 5'd9, 5'd2, 5'd16};
    cap_plan[7] = CAP_W'($urandom_range(0, 31));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme keys and values, both operations, default capacity
    send_request(MODE_GET, 32'h0000_0000, 32'h0000_0000);
    send_request(MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_request(MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_request(MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(MODE_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(MODE_GET, 32'hFFFF_FFFF, 32'h1234_5678);
    send_request(MODE_PUT, 32'h8000_0000, 32'h0000_0000);
    send_request(MODE_GET, 32'h8000_0000, 32'hFFFF_FFFF);

    // capacity below occupancy: each missing put swaps one entry out
    write_capacity(5'd2);
    send_request(MODE_PUT, 32'd1, 32'd1);
    send_request(MODE_PUT, 32'd2, 32'd2);

    // zero capacity: puts change nothing, gets still served
    write_capacity(5'd0);
    send_request(MODE_PUT, 32'd3, 32'd3);
    send_request(MODE_PUT, 32'd2, 32'd5);
    send_request(MODE_GET, 32'd2, 32'd0);
    send_request(MODE_GET, 32'd3, 32'd0);

    // capacity above the entry count, then drive one count into saturation
    write_capacity(5'd31);
    send_request(MODE_PUT, 32'd5, 32'h5555_AAAA);
    repeat (7) send_request(MODE_GET, 32'd5, 32'd0);

    // random phases over capacities and idling patterns
    for (int seg = 0; seg < 8; seg++) begin
      set_idling(seg % 4);
      write_capacity(cap_plan[seg]);
      for (int i = 0; i < KEY_POOL; i++) key_pool[i] = $urandom;
      key_pool[KEY_POOL-1] = 32'h8000_0000;
      key_pool[KEY_POOL-2] = 32'h7FFF_FFFF;
      n_items = (cap_plan[seg] == 0) ? 60 : 240;
      for (int i = 0; i < n_items; i++) begin
        if (i == n_items / 2)
          wait_drained();
        pick = $urandom_range(99);
        if (pick < 8)
          k = $urandom;
        else if (pick < 45)
          k = key_pool[$urandom_range(3)];
        else
          k = key_pool[$urandom_range(KEY_POOL-1)];
        send_request($urandom_range(1) ? MODE_PUT : MODE_GET, k, $urandom);
      end
    end

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
